// ===== hdl/tac_pkg.sv =====
// Shared types and constants for the tilt alarm controller.
`default_nettype none

package tac_pkg;

    localparam int TILT_LIMIT_WIDTH = 15;
    localparam int MS_WIDTH         = 10;
    localparam int SWEEP_WIDTH      = 12;
    localparam int TONE_WIDTH       = 12;
    localparam int ACCEL_WIDTH      = 16;
    localparam int CFG_INDEX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH   = 15;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_TILT_LIMIT_Y  = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_TILT_LIMIT_Z  = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_DEBOUNCE_MS   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_CHIRP_PERIOD  = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_SWEEP_LOW     = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_SWEEP_HIGH    = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_SWEEP_STEP    = 3'd6;

    localparam logic [TILT_LIMIT_WIDTH-1:0] TILT_LIMIT_RESET   = 15'd11500;
    localparam logic [MS_WIDTH-1:0]         DEBOUNCE_MS_RESET  = 10'd25;
    localparam logic [MS_WIDTH-1:0]         CHIRP_PERIOD_RESET = 10'd20;
    localparam logic [SWEEP_WIDTH-1:0]      SWEEP_LOW_RESET    = 12'd600;
    localparam logic [SWEEP_WIDTH-1:0]      SWEEP_HIGH_RESET   = 12'd2500;
    localparam logic [SWEEP_WIDTH-1:0]      SWEEP_STEP_RESET   = 12'd50;

    typedef struct packed {
        logic [TILT_LIMIT_WIDTH-1:0] tilt_limit_y;
        logic [TILT_LIMIT_WIDTH-1:0] tilt_limit_z;
        logic [MS_WIDTH-1:0]         debounce_ms;
        logic [MS_WIDTH-1:0]         chirp_period_ms;
        logic [SWEEP_WIDTH-1:0]      sweep_low;
        logic [SWEEP_WIDTH-1:0]      sweep_high;
        logic [SWEEP_WIDTH-1:0]      sweep_step;
    } cfg_t;

    typedef struct packed {
        logic                          tick;
        logic                          switch_edge;
        logic signed [ACCEL_WIDTH-1:0] accel_y;
        logic signed [ACCEL_WIDTH-1:0] accel_z;
    } item_t;

    typedef struct packed {
        logic [TONE_WIDTH-1:0] tone_frequency;
        logic                  alarm_active;
        logic                  redraw_display;
        logic                  button_accepted;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/tac_cfg_regs.sv =====
// Configuration register file of the tilt alarm controller.
`default_nettype none

module tac_cfg_regs (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [tac_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [tac_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    output tac_pkg::cfg_t                             cfg
);

    tac_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.tilt_limit_y    <= tac_pkg::TILT_LIMIT_RESET;
            cfg_reg.tilt_limit_z    <= tac_pkg::TILT_LIMIT_RESET;
            cfg_reg.debounce_ms     <= tac_pkg::DEBOUNCE_MS_RESET;
            cfg_reg.chirp_period_ms <= tac_pkg::CHIRP_PERIOD_RESET;
            cfg_reg.sweep_low       <= tac_pkg::SWEEP_LOW_RESET;
            cfg_reg.sweep_high      <= tac_pkg::SWEEP_HIGH_RESET;
            cfg_reg.sweep_step      <= tac_pkg::SWEEP_STEP_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                tac_pkg::CFG_IDX_TILT_LIMIT_Y: begin
                    cfg_reg.tilt_limit_y <= cfg_data[tac_pkg::TILT_LIMIT_WIDTH-1:0];
                end
                tac_pkg::CFG_IDX_TILT_LIMIT_Z: begin
                    cfg_reg.tilt_limit_z <= cfg_data[tac_pkg::TILT_LIMIT_WIDTH-1:0];
                end
                tac_pkg::CFG_IDX_DEBOUNCE_MS: begin
                    cfg_reg.debounce_ms <= cfg_data[tac_pkg::MS_WIDTH-1:0];
                end
                tac_pkg::CFG_IDX_CHIRP_PERIOD: begin
                    cfg_reg.chirp_period_ms <= cfg_data[tac_pkg::MS_WIDTH-1:0];
                end
                tac_pkg::CFG_IDX_SWEEP_LOW: begin
                    cfg_reg.sweep_low <= cfg_data[tac_pkg::SWEEP_WIDTH-1:0];
                end
                tac_pkg::CFG_IDX_SWEEP_HIGH: begin
                    cfg_reg.sweep_high <= cfg_data[tac_pkg::SWEEP_WIDTH-1:0];
                end
                tac_pkg::CFG_IDX_SWEEP_STEP: begin
                    cfg_reg.sweep_step <= cfg_data[tac_pkg::SWEEP_WIDTH-1:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tac_core.sv =====
// Alarm state, button debouncer and tone sweep, advanced once per item.
`default_nettype none

module tac_core #(
    parameter int ELAPSED_WIDTH = 16,
    parameter int FREQ_WIDTH    = 12
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step,
    input  wire tac_pkg::cfg_t   cfg,
    input  wire tac_pkg::item_t  item,
    output tac_pkg::result_t     result
);

    localparam int EW = (ELAPSED_WIDTH > tac_pkg::MS_WIDTH) ? ELAPSED_WIDTH
                                                            : tac_pkg::MS_WIDTH;
    localparam int FW = (FREQ_WIDTH > tac_pkg::SWEEP_WIDTH) ? FREQ_WIDTH
                                                            : tac_pkg::SWEEP_WIDTH;
    localparam int SW = FW + 1;
    localparam int TW = (FREQ_WIDTH > tac_pkg::TONE_WIDTH) ? FREQ_WIDTH
                                                           : tac_pkg::TONE_WIDTH;
    localparam int AW = tac_pkg::ACCEL_WIDTH + 1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PRESS,
        PH_WAIT,
        PH_RELEASE
    } phase_t;

    phase_t                   phase_reg, phase_next;
    logic                     pending_reg, pending_next;
    logic [ELAPSED_WIDTH-1:0] debounce_reg, debounce_next, debounce_inc;
    logic [ELAPSED_WIDTH-1:0] chirp_reg, chirp_next, chirp_inc;
    logic                     latch_reg, latch_next;
    logic                     shown_reg;
    logic [FREQ_WIDTH-1:0]    freq_reg, freq_next;
    logic                     rising_reg, rising_next;
    logic [FREQ_WIDTH-1:0]    tone_reg, tone_next;

    logic                     pending_now;
    logic                     accepted;
    logic                     debounce_done;
    logic                     chirp_due;
    logic                     tilt;
    logic [AW-1:0]            abs_y, abs_z;
    logic [SW-1:0]            freq_ext, step_ext, sum, stepped;
    logic [TW-1:0]            tone_ext;

    // A sample of -32768 gives 32768 here, above any limit.
    always_comb begin
        abs_y = item.accel_y[tac_pkg::ACCEL_WIDTH-1]
              ? (AW'(1) << tac_pkg::ACCEL_WIDTH) - AW'($unsigned(item.accel_y))
              : AW'($unsigned(item.accel_y));
        abs_z = item.accel_z[tac_pkg::ACCEL_WIDTH-1]
              ? (AW'(1) << tac_pkg::ACCEL_WIDTH) - AW'($unsigned(item.accel_z))
              : AW'($unsigned(item.accel_z));
        tilt = (abs_y > AW'(cfg.tilt_limit_y)) || (abs_z > AW'(cfg.tilt_limit_z));
    end

    always_comb begin
        debounce_inc = (item.tick && (debounce_reg != '1)) ? debounce_reg + 1'b1
                                                          : debounce_reg;
        chirp_inc    = (item.tick && (chirp_reg != '1)) ? chirp_reg + 1'b1 : chirp_reg;
        debounce_done = EW'(debounce_inc) >= EW'(cfg.debounce_ms);
        chirp_due     = EW'(chirp_inc) >= EW'(cfg.chirp_period_ms);
        pending_now   = pending_reg | item.switch_edge;

        phase_next    = phase_reg;
        pending_next  = pending_now;
        debounce_next = debounce_inc;
        accepted      = 1'b0;
        case (phase_reg)
            PH_IDLE: begin
                if (pending_now) begin
                    pending_next  = 1'b0;
                    debounce_next = '0;
                    phase_next    = PH_PRESS;
                end
            end
            PH_PRESS: begin
                if (debounce_done) begin
                    accepted   = 1'b1;
                    phase_next = PH_WAIT;
                end
            end
            PH_WAIT: begin
                if (pending_now) begin
                    pending_next  = 1'b0;
                    debounce_next = '0;
                    phase_next    = PH_RELEASE;
                end
            end
            PH_RELEASE: begin
                if (debounce_done) begin
                    phase_next = PH_IDLE;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        // A press clears the latch, and tilt in the same item sets it again.
        latch_next = tilt | (latch_reg & ~accepted);

        freq_ext = SW'(freq_reg);
        step_ext = SW'(cfg.sweep_step);
        sum      = freq_ext + step_ext;
        if (rising_reg) begin
            stepped = (sum > SW'({FREQ_WIDTH{1'b1}})) ? SW'({FREQ_WIDTH{1'b1}}) : sum;
        end else begin
            stepped = (freq_ext > step_ext) ? freq_ext - step_ext : '0;
        end

        chirp_next  = chirp_inc;
        // A press also silences the tone until the next chirp update.
        tone_next   = accepted ? '0 : tone_reg;
        freq_next   = freq_reg;
        rising_next = rising_reg;
        if (!latch_next) begin
            tone_next = '0;
        end else if (chirp_due) begin
            chirp_next = '0;
            tone_next  = freq_reg;
            freq_next  = stepped[FREQ_WIDTH-1:0];
            // The low turn point wins when both turn tests hold.
            if (stepped <= SW'(cfg.sweep_low)) begin
                rising_next = 1'b1;
            end else if (stepped >= SW'(cfg.sweep_high)) begin
                rising_next = 1'b0;
            end
        end

        tone_ext = TW'(tone_next);
        result.tone_frequency  = tone_ext[tac_pkg::TONE_WIDTH-1:0];
        result.alarm_active    = latch_next;
        result.redraw_display  = latch_next ^ shown_reg;
        result.button_accepted = accepted;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            pending_reg  <= 1'b0;
            debounce_reg <= '0;
            chirp_reg    <= '0;
            latch_reg    <= 1'b0;
            shown_reg    <= 1'b0;
            freq_reg     <= FREQ_WIDTH'(tac_pkg::SWEEP_LOW_RESET);
            rising_reg   <= 1'b1;
            tone_reg     <= '0;
        end else if (step) begin
            phase_reg    <= phase_next;
            pending_reg  <= pending_next;
            debounce_reg <= debounce_next;
            chirp_reg    <= chirp_next;
            latch_reg    <= latch_next;
            shown_reg    <= latch_next;
            freq_reg     <= freq_next;
            rising_reg   <= rising_next;
            tone_reg     <= tone_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tilt_alarm_controller.sv =====
// Top level of the tilt alarm controller: input and result registers around the core.
//
// Usage:
//   Input items (s_tick, s_switch_edge, s_accel_y, s_accel_z) arrive on a
//   valid/ready channel and each one yields exactly one result item on the
//   m_ channel: tone frequency, alarm state, redraw pulse and press flag.
//   An item accepted at one clock edge sits in the input register, is
//   processed by the core at the next edge that has room in the result
//   register, and is offered on m_valid right after. Throughput is one item
//   per cycle while the receiver keeps up; the core state advances once per
//   item, so consecutive items follow each other without gaps.
//   When the receiver stalls, the result register holds its item and the
//   input register still takes one more item before s_ready drops.
//   Configuration writes on cfg_valid/cfg_index/cfg_data are always taken
//   (cfg_ready is tied high) and should be issued only while no items are
//   in flight. Indexes beyond the register list are ignored.
//   Synchronous reset (aresetn low) empties both registers, restores the
//   register defaults and clears the alarm, debouncer and tone sweep.
`default_nettype none

module tilt_alarm_controller #(
    parameter int ELAPSED_WIDTH = 16,
    parameter int FREQ_WIDTH    = 12
) (
    input  wire logic                                     aclk,
    input  wire logic                                     aresetn,
    input  wire logic                                     cfg_valid,
    output logic                                          cfg_ready,
    input  wire logic [tac_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index,
    input  wire logic [tac_pkg::CFG_DATA_WIDTH-1:0]       cfg_data,
    input  wire logic                                     s_valid,
    output logic                                          s_ready,
    input  wire logic                                     s_tick,
    input  wire logic                                     s_switch_edge,
    input  wire logic signed [tac_pkg::ACCEL_WIDTH-1:0]   s_accel_y,
    input  wire logic signed [tac_pkg::ACCEL_WIDTH-1:0]   s_accel_z,
    output logic                                          m_valid,
    input  wire logic                                     m_ready,
    output logic [tac_pkg::TONE_WIDTH-1:0]                m_tone_frequency,
    output logic                                          m_alarm_active,
    output logic                                          m_redraw_display,
    output logic                                          m_button_accepted
);

    tac_pkg::cfg_t    cfg;
    tac_pkg::item_t   in_reg;
    logic             in_valid_reg;
    tac_pkg::result_t result;
    tac_pkg::result_t out_reg;
    logic             out_valid_reg;
    logic             advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    tac_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tac_core #(
        .ELAPSED_WIDTH (ELAPSED_WIDTH),
        .FREQ_WIDTH    (FREQ_WIDTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .cfg     (cfg),
        .item    (in_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg.tick        <= s_tick;
            in_reg.switch_edge <= s_switch_edge;
            in_reg.accel_y     <= s_accel_y;
            in_reg.accel_z     <= s_accel_z;
        end
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_tone_frequency  = out_reg.tone_frequency;
    assign m_alarm_active    = out_reg.alarm_active;
    assign m_redraw_display  = out_reg.redraw_display;
    assign m_button_accepted = out_reg.button_accepted;

`ifndef SYNTH
    // The tone is silent whenever the delivered alarm state is clear.
    a_silent_when_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_alarm_active) |-> (m_tone_frequency == '0))
        else $error("tone driven while alarm is clear");

    // An item moved out of the input register shows up as a valid result.
    a_advance_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("processed item not presented on result channel");

    // An accepted input item is held in the input register next cycle.
    a_accept_fills_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> in_valid_reg)
        else $error("accepted item lost before processing");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tilt_alarm_controller_tb.sv =====
// Self-checking testbench for the tilt alarm controller with a built-in alarm tracker.
module tilt_alarm_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tac_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int ELAPSED_MAX = 65535;
    localparam int FREQ_MAX    = 4095;
    localparam int PHASE_ITEMS = 170;
    localparam int HOLD_AFTER  = 600;
    localparam int HOLD_CYCLES = 300;

    // Index past the end of the register list; writes to it must be dropped.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_IDX_UNUSED = 3'd7;

    localparam cfg_t REG_DEFAULTS = '{
        TILT_LIMIT_RESET, TILT_LIMIT_RESET, DEBOUNCE_MS_RESET, CHIRP_PERIOD_RESET,
        SWEEP_LOW_RESET, SWEEP_HIGH_RESET, SWEEP_STEP_RESET
    };

    typedef enum logic [1:0] {DB_IDLE, DB_PRESS, DB_WAIT, DB_RELEASE} debounce_phase_t;

    class tilt_alarm_tracker;
        cfg_t            regs;
        debounce_phase_t phase;
        bit              edge_pending;
        int              debounce_count;
        int              chirp_count;
        bit              alarm;
        bit              frowny;
        int              sweep_freq;
        bit              sweep_rising;
        logic [11:0]     tone_hold;
        result_t         expected_results[$];
        int              errors;

        function new();
            regs           = REG_DEFAULTS;
            phase          = DB_IDLE;
            edge_pending   = 1'b0;
            debounce_count = 0;
            chirp_count    = 0;
            alarm          = 1'b0;
            frowny         = 1'b0;
            sweep_freq     = int'(SWEEP_LOW_RESET);
            sweep_rising   = 1'b1;
            tone_hold      = '0;
            errors         = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_WIDTH-1:0] idx,
                                     logic [CFG_DATA_WIDTH-1:0] data);
            case (idx)
                CFG_IDX_TILT_LIMIT_Y: regs.tilt_limit_y    = data[TILT_LIMIT_WIDTH-1:0];
                CFG_IDX_TILT_LIMIT_Z: regs.tilt_limit_z    = data[TILT_LIMIT_WIDTH-1:0];
                CFG_IDX_DEBOUNCE_MS:  regs.debounce_ms     = data[MS_WIDTH-1:0];
                CFG_IDX_CHIRP_PERIOD: regs.chirp_period_ms = data[MS_WIDTH-1:0];
                CFG_IDX_SWEEP_LOW:    regs.sweep_low       = data[SWEEP_WIDTH-1:0];
                CFG_IDX_SWEEP_HIGH:   regs.sweep_high      = data[SWEEP_WIDTH-1:0];
                CFG_IDX_SWEEP_STEP:   regs.sweep_step      = data[SWEEP_WIDTH-1:0];
                default: ;
            endcase
        endfunction

        function void note_item(item_t it);
            result_t r;
            bit      accepted;
            bit      redraw;
            int      mag_y;
            int      mag_z;
            int      f;
            accepted = 1'b0;
            if (it.tick) begin
                if (debounce_count < ELAPSED_MAX) debounce_count++;
                if (chirp_count < ELAPSED_MAX) chirp_count++;
            end
            if (it.switch_edge) edge_pending = 1'b1;

            case (phase)
                DB_IDLE, DB_WAIT: begin
                    if (edge_pending) begin
                        edge_pending   = 1'b0;
                        debounce_count = 0;
                        phase = (phase == DB_IDLE) ? DB_PRESS : DB_RELEASE;
                    end
                end
                DB_PRESS: begin
                    if (debounce_count >= int'(regs.debounce_ms)) begin
                        accepted = 1'b1;
                        phase    = DB_WAIT;
                    end
                end
                default: begin
                    if (debounce_count >= int'(regs.debounce_ms)) phase = DB_IDLE;
                end
            endcase

            if (accepted) begin
                alarm     = 1'b0;
                tone_hold = '0;
            end

            // The most negative sample has a magnitude of 32768, above any limit.
            mag_y = $signed(it.accel_y);
            mag_z = $signed(it.accel_z);
            if (mag_y < 0) mag_y = -mag_y;
            if (mag_z < 0) mag_z = -mag_z;
            if (mag_y > int'(regs.tilt_limit_y) || mag_z > int'(regs.tilt_limit_z))
                alarm = 1'b1;

            redraw = (alarm != frowny);
            frowny = alarm;

            if (!alarm) begin
                tone_hold = '0;
            end else if (chirp_count >= int'(regs.chirp_period_ms)) begin
                chirp_count = 0;
                tone_hold   = sweep_freq[11:0];
                if (sweep_rising) begin
                    f = sweep_freq + int'(regs.sweep_step);
                    if (f > FREQ_MAX) f = FREQ_MAX;
                end else begin
                    f = (sweep_freq > int'(regs.sweep_step)) ?
                        sweep_freq - int'(regs.sweep_step) : 0;
                end
                sweep_freq = f;
                // The low turn point is tested last so it wins when both hold.
                if (f >= int'(regs.sweep_high)) sweep_rising = 1'b0;
                if (f <= int'(regs.sweep_low)) sweep_rising = 1'b1;
            end

            r.tone_frequency  = tone_hold;
            r.alarm_active    = alarm;
            r.redraw_display  = redraw;
            r.button_accepted = accepted;
            expected_results.push_back(r);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t ns: result item with none expected, actual tone %0d",
                         $time, got.tone_frequency);
                return;
            end
            want = expected_results.pop_front();
            compare_field("tone_frequency", want.tone_frequency, got.tone_frequency);
            compare_field("alarm_active", want.alarm_active, got.alarm_active);
            compare_field("redraw_display", want.redraw_display, got.redraw_display);
            compare_field("button_accepted", want.button_accepted, got.button_accepted);
        endfunction
    endclass

    logic                              aclk;
    logic                              aresetn;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0]        cfg_index;
    logic [CFG_DATA_WIDTH-1:0]         cfg_data;
    logic                              s_valid;
    logic                              s_ready;
    logic                              s_tick;
    logic                              s_switch_edge;
    logic signed [ACCEL_WIDTH-1:0]     s_accel_y;
    logic signed [ACCEL_WIDTH-1:0]     s_accel_z;
    logic                              m_valid;
    logic                              m_ready;
    logic [TONE_WIDTH-1:0]             m_tone_frequency;
    logic                              m_alarm_active;
    logic                              m_redraw_display;
    logic                              m_button_accepted;

    tilt_alarm_tracker tracker;
    int                cycle_count   = 0;
    bit                no_gaps       = 1'b0;
    int                results_seen  = 0;
    bit                long_hold_done = 1'b0;

    tilt_alarm_controller u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_tick            (s_tick),
        .s_switch_edge     (s_switch_edge),
        .s_accel_y         (s_accel_y),
        .s_accel_z         (s_accel_z),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_tone_frequency  (m_tone_frequency),
        .m_alarm_active    (m_alarm_active),
        .m_redraw_display  (m_redraw_display),
        .m_button_accepted (m_button_accepted)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Mostly no gap, some short ones and now and then a long one.
    function automatic int pick_gap();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic item_t make_item(bit tick, bit sw, int y, int z);
        item_t it;
        it.tick        = tick;
        it.switch_edge = sw;
        it.accel_y     = y[15:0];
        it.accel_z     = z[15:0];
        return it;
    endfunction

    function automatic logic [15:0] rand_accel();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 85) begin
            v = int'($urandom_range(0, 8000)) - 4000;
            return v[15:0];
        end
        if (r < 95) return 16'($urandom());
        case ($urandom_range(0, 3))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            default: return 16'h0000;
        endcase
    endfunction

    function automatic item_t rand_item();
        item_t it;
        it.tick        = ($urandom_range(0, 99) < 60);
        it.switch_edge = ($urandom_range(0, 99) < 10);
        it.accel_y     = rand_accel();
        it.accel_z     = rand_accel();
        return it;
    endfunction

    function automatic cfg_t rand_cfg();
        cfg_t c;
        c.tilt_limit_y    = 15'($urandom_range(2000, 32767));
        c.tilt_limit_z    = 15'($urandom_range(2000, 32767));
        c.debounce_ms     = 10'($urandom_range(0, 6));
        c.chirp_period_ms = 10'($urandom_range(0, 4));
        c.sweep_low       = 12'($urandom_range(0, 4095));
        c.sweep_high      = 12'($urandom_range(0, 4095));
        c.sweep_step      = 12'($urandom_range(0, 800));
        return c;
    endfunction

    task automatic send_item(item_t it);
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_tick        <= it.tick;
        s_switch_edge <= it.switch_edge;
        s_accel_y     <= it.accel_y;
        s_accel_z     <= it.accel_z;
        do @(posedge aclk); while (!s_ready);
        tracker.note_item(it);
    endtask

    task automatic pause_sender(int n);
        if (n > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // Stop offering items and wait until every result has come back.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx,
                             logic [CFG_DATA_WIDTH-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        tracker.write_register(idx, data);
    endtask

    task automatic load_config(cfg_t c);
        write_reg(CFG_IDX_TILT_LIMIT_Y, CFG_DATA_WIDTH'(c.tilt_limit_y));
        write_reg(CFG_IDX_TILT_LIMIT_Z, CFG_DATA_WIDTH'(c.tilt_limit_z));
        write_reg(CFG_IDX_DEBOUNCE_MS, CFG_DATA_WIDTH'(c.debounce_ms));
        write_reg(CFG_IDX_CHIRP_PERIOD, CFG_DATA_WIDTH'(c.chirp_period_ms));
        write_reg(CFG_IDX_SWEEP_LOW, CFG_DATA_WIDTH'(c.sweep_low));
        write_reg(CFG_IDX_SWEEP_HIGH, CFG_DATA_WIDTH'(c.sweep_high));
        write_reg(CFG_IDX_SWEEP_STEP, CFG_DATA_WIDTH'(c.sweep_step));
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stalls, plus one long hold-off so the block backs up.
    initial begin
        int hold;
        hold = 0;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(negedge aclk);
            if (!long_hold_done && results_seen >= HOLD_AFTER) begin
                hold           = HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
                hold = pick_gap();
            end
            @(posedge aclk);
            if (m_valid && m_ready) begin
                tracker.check_result('{m_tone_frequency, m_alarm_active,
                                       m_redraw_display, m_button_accepted});
                results_seen++;
            end
        end
    end

    initial begin
        item_t early_items[$];
        item_t press_items[$];
        cfg_t  c;
        s_valid       = 1'b0;
        s_tick        = 1'b0;
        s_switch_edge = 1'b0;
        s_accel_y     = '0;
        s_accel_z     = '0;
        m_ready       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        aresetn       = 1'b0;
        tracker       = new();

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset thresholds: values at, just above and far beyond the tilt limit.
        early_items.push_back(make_item(0, 0, 0, 0));
        early_items.push_back(make_item(1, 0, 11500, -11500));
        early_items.push_back(make_item(1, 0, -32768, 0));
        early_items.push_back(make_item(0, 0, 11501, 0));
        early_items.push_back(make_item(0, 0, 0, 32767));
        early_items.push_back(make_item(1, 1, -11501, -32768));
        foreach (early_items[i]) send_item(early_items[i]);
        drain();

        c                 = REG_DEFAULTS;
        c.debounce_ms     = '0;
        c.chirp_period_ms = '0;
        load_config(c);

        // Zero settle time: presses, releases, press with tilt, and edges that
        // arrive while a debounce phase runs and must stay pending.
        press_items.push_back(make_item(0, 0, 0, 0));
        press_items.push_back(make_item(0, 1, 0, 0));
        press_items.push_back(make_item(0, 0, 0, 0));
        press_items.push_back(make_item(0, 1, 20000, 0));
        press_items.push_back(make_item(0, 0, 0, -20000));
        press_items.push_back(make_item(1, 1, 0, 0));
        press_items.push_back(make_item(1, 1, 0, 0));
        press_items.push_back(make_item(0, 0, 0, 0));
        press_items.push_back(make_item(1, 0, -32768, 1));
        press_items.push_back(make_item(1, 0, 1, 32767));
        press_items.push_back(make_item(0, 1, -1, -1));
        press_items.push_back(make_item(1, 0, 0, 0));
        foreach (press_items[i]) send_item(press_items[i]);
        drain();

        for (int p = 0; p < 9; p++) begin
            case (p)
                0: c = REG_DEFAULTS;
                1: c = '0;
                2: c = '{15'h7fff, 15'h7fff, 10'd1000, 10'd1000, 12'hfff, 12'hfff, 12'hfff};
                3: c = '{15'd6000, 15'd6000, 10'd2, 10'd0, 12'd0, 12'hfff, 12'hfff};
                default: c = rand_cfg();
            endcase
            if (p == 1) write_reg(CFG_IDX_UNUSED, '1);
            load_config(c);
            no_gaps = (p % 3 == 2);
            repeat (PHASE_ITEMS) begin
                pause_sender(pick_gap());
                send_item(rand_item());
            end
            drain();
        end

        if (tracker.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
